// ===== hdl/sbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite bitplane converter package
// Shared command codes, size defaults and payload structs.
// ----------------------------------------------------------------------------
package sbpc_pkg;

  localparam int RowsDef   = 16;
  localparam int ColsDef   = 16;
  localparam int PlanesDef = 4;

  // Widest pixel the store can hold.
  localparam int MaxPlanes = 8;
  // Columns a 16-bit plane word can reach.
  localparam int WordBits  = 16;

  localparam logic [1:0] CmdWrWord = 2'd0;
  localparam logic [1:0] CmdRdWord = 2'd1;
  localparam logic [1:0] CmdWrPix  = 2'd2;
  localparam logic [1:0] CmdRdPix  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  plane;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [15:0] word_in;
    logic [3:0]  pixel_in;
  } sbpc_in_t;

  typedef struct packed {
    logic [15:0] word_out;
    logic [3:0]  pixel_out;
  } sbpc_out_t;

endpackage

// ===== hdl/sprite_bitplane_pixel_converter_top.sv =====
// ----------------------------------------------------------------------------
// Sprite bitplane pixel converter
// Row store of a sprite pattern; converts plane words to and from pixels.
// ----------------------------------------------------------------------------
// Timing: the row read registers on the input transfer; modify, write-back and
//   the result register share the edge on which stage one advances.
// Throughput: one command per cycle; the row memory has one read and one write
//   port, read on transfer, written back as stage one advances, with forwarding
//   on a row match. A stalled result holds stage one and stalls the input.
// Reset: rst_ni clears the per-row valid bits, so the pattern reads as zeros
//   at once; no clearing pass is needed.
module sprite_bitplane_pixel_converter_top
  import sbpc_pkg::*;
#(
  parameter int ROWS   = RowsDef,
  parameter int COLS   = ColsDef,
  parameter int PLANES = PlanesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbpc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbpc_out_t out_data_o
);

  localparam int RowBits  = COLS * PLANES;
  localparam int RowAw    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RowExtW  = (RowAw > 4) ? RowAw : 4;
  localparam int WordCols = (COLS < WordBits) ? COLS : WordBits;

  logic [RowBits-1:0] mem_q [ROWS];
  logic [ROWS-1:0]    row_vld_q;

  logic               in_fire;
  logic [RowExtW-1:0] in_row_ext;
  logic [RowAw-1:0]   in_addr;

  logic               s1_valid_q;
  sbpc_in_t           s1_q;
  logic               s1_row_ok_q;
  logic [RowAw-1:0]   s1_addr_q;
  logic               s1_adv;

  logic [RowBits-1:0] rd_data_q;
  logic               rd_vld_q;
  logic               fwd_q;
  logic [RowBits-1:0] fwd_data_q;

  logic [RowBits-1:0] row_cur;
  logic [RowBits-1:0] row_wword;
  logic [RowBits-1:0] row_wpix;
  logic [RowBits-1:0] row_new;
  logic [15:0]        word_rd;
  logic [MaxPlanes-1:0] pix_rd;
  logic [MaxPlanes-1:0] pix_ext;
  logic               mem_we;
  logic               fwd_hit;

  logic               out_valid_q;
  sbpc_out_t          out_data_q;
  sbpc_out_t          out_data_d;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_row_ext = RowExtW'(in_data_i.row);
  assign in_addr    = in_row_ext[RowAw-1:0];

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Modify the row read for the command in stage one.
  always_comb begin
    row_cur   = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);
    row_wword = row_cur;
    row_wpix  = row_cur;
    word_rd   = '0;
    pix_rd    = '0;
    pix_ext   = MaxPlanes'(s1_q.pixel_in);
    for (int c = 0; c < WordCols; c++) begin
      for (int q = 0; q < PLANES; q++) begin
        if (int'(s1_q.plane) == q) begin
          word_rd[15-c]          = row_cur[c*PLANES+q];
          row_wword[c*PLANES+q]  = s1_q.word_in[15-c];
        end
      end
    end
    for (int c = 0; c < COLS; c++) begin
      if (int'(s1_q.column) == c) begin
        row_wpix[c*PLANES +: PLANES] = pix_ext[PLANES-1:0];
        pix_rd[PLANES-1:0]           = row_cur[c*PLANES +: PLANES];
      end
    end
    row_new = (s1_q.command == CmdWrWord) ? row_wword : row_wpix;
  end

  // Out-of-range plane or column leaves the row unchanged, so a write is harmless.
  assign mem_we  = s1_adv && s1_row_ok_q &&
                   (s1_q.command == CmdWrWord || s1_q.command == CmdWrPix);
  assign fwd_hit = in_fire && mem_we && (in_addr == s1_addr_q);

  always_comb begin
    out_data_d = '0;
    if (s1_row_ok_q && s1_q.command == CmdRdWord) begin
      out_data_d.word_out = word_rd;
    end
    if (s1_row_ok_q && s1_q.command == CmdRdPix) begin
      out_data_d.pixel_out = pix_rd[3:0];
    end
  end

  // Row memory: one read on transfer, one write-back from stage one.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[s1_addr_q] <= row_new;
    end
    if (in_fire) begin
      rd_data_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_q[s1_addr_q] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q <= row_vld_q[in_addr];
        fwd_q    <= fwd_hit;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q        <= in_data_i;
      s1_row_ok_q <= int'(in_data_i.row) < ROWS;
      s1_addr_q   <= in_addr;
    end
    if (fwd_hit) begin
      fwd_data_q <= row_new;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while pipeline has room");

  a_fire_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted command missing from stage one");

  a_fwd_hit_sets_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit |=> fwd_q && s1_valid_q)
    else $error("forwarded row not selected for stage one");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> row_vld_q[$past(s1_addr_q)])
    else $error("written row not marked valid");

  a_s1_advance_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("stage one advanced without loading result");

endmodule
